[hw/rtl/pfba_pkg.sv]
// Shared types and constants for the page frame bitmap allocator.
package pfba_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned WORDS    = 128;
	localparam int unsigned ADDR_W   = $clog2(WORDS);
	localparam int unsigned BIT_W    = $clog2(WORD_W);
	localparam int unsigned FRAME_W  = 12;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned WCNT_W   = ADDR_W + 1;

	localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = COUNT_W'(4096);
	localparam logic [COUNT_W-1:0] FRAME_LIMIT     = COUNT_W'(WORDS * WORD_W);
	localparam logic [WORD_W-1:0]  WORD_FULL       = '1;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_TEST  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOCHANGE = 2'd1;
	localparam logic [1:0] ST_NOFRAME  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FRAME_W-1:0] frame_number;
		logic               is_kernel;
		logic               writable;
	} pfba_req_t;

	typedef struct packed {
		logic               entry_present;
		logic               entry_writable;
		logic               entry_user;
		logic [FRAME_W-1:0] entry_frame;
		logic [1:0]         status;
		logic               frame_busy;
	} pfba_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} pfba_mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LOOK,
		S_CHECK,
		S_DONE
	} pfba_state_t;

endpackage

[hw/rtl/pfba_bitmap_mem.sv]
// Usage bitmap memory: 128 x 32 words, registered read, per-row valid flags.
module pfba_bitmap_mem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfba_pkg::pfba_mem_req_t       mem_req,
	output logic [pfba_pkg::WORD_W-1:0]   rd_data
);
	import pfba_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  row_valid_q;
	logic [WORD_W-1:0] rd_data_s1;
	logic              rd_valid_s1;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.wr_addr] <= mem_req.wr_data;
		end
		if (mem_req.rd_en) begin
			rd_data_s1 <= mem[mem_req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				row_valid_q[mem_req.wr_addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_valid_s1 <= row_valid_q[mem_req.rd_addr];
			end
		end
	end

	// rows never written read as all free
	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

[hw/rtl/pfba_seq.sv]
// Request sequencer: first-fit word scan, read-modify-write of the bitmap.
module pfba_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pfba_pkg::pfba_req_t           in_data,
	input  logic [pfba_pkg::COUNT_W-1:0]  frame_count,
	output pfba_pkg::pfba_mem_req_t       mem_req,
	input  logic [pfba_pkg::WORD_W-1:0]   rd_data,
	output logic                          rsp_valid,
	output pfba_pkg::pfba_rsp_t           rsp,
	input  logic                          rsp_take
);
	import pfba_pkg::*;

	pfba_state_t       state_q, state_d;
	pfba_req_t         req_q;
	pfba_rsp_t         rsp_q, rsp_d;
	logic [WCNT_W-1:0] words_q, words_d;
	logic [WCNT_W-1:0] issue_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [ADDR_W-1:0] last_addr;
	logic [COUNT_W-1:0] limit;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] first_free;
	logic [BIT_W-1:0]  free_idx;
	logic              word_full;
	logic [WORD_W-1:0] frame_mask;

	assign limit     = (frame_count > FRAME_LIMIT) ? FRAME_LIMIT : frame_count;
	assign words_d   = limit[COUNT_W-1:BIT_W];
	assign last_addr = ADDR_W'(words_q - WCNT_W'(1));
	assign word_full = (rd_data == WORD_FULL);
	assign free_bits = ~rd_data;
	assign first_free = free_bits & (~free_bits + WORD_W'(1));
	assign frame_mask = WORD_W'(1) << req_q.frame_number[BIT_W-1:0];

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (first_free[i]) begin
				free_idx = free_idx | BIT_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.mode)
						MODE_ALLOC: begin
							if (in_data.frame_number != '0 || words_d == '0) begin
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						MODE_FREE: state_d = (in_data.frame_number == '0) ? S_DONE : S_LOOK;
						MODE_TEST: state_d = S_LOOK;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (rd_vld_s1 && (!word_full || rd_addr_s1 == last_addr)) begin
					state_d = S_DONE;
				end
			end
			S_LOOK:  state_d = S_CHECK;
			S_CHECK: state_d = S_DONE;
			S_DONE: begin
				if (rsp_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		rsp_valid       = 1'b0;
		mem_req         = '0;
		rsp_d           = '0;
		rsp_d.status    = ST_NOCHANGE;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_data.mode == MODE_ALLOC) begin
					if (in_data.frame_number != '0) begin
						rsp_d.entry_frame = in_data.frame_number;
					end else begin
						rsp_d.status = ST_NOFRAME;
					end
				end
			end
			S_SCAN: begin
				mem_req.rd_en   = (issue_q < words_q);
				mem_req.rd_addr = issue_q[ADDR_W-1:0];
				mem_req.wr_en   = rd_vld_s1 && !word_full;
				mem_req.wr_addr = rd_addr_s1;
				mem_req.wr_data = rd_data | first_free;
				if (!word_full) begin
					rsp_d.entry_present  = 1'b1;
					rsp_d.entry_writable = req_q.writable;
					rsp_d.entry_user     = !req_q.is_kernel;
					rsp_d.entry_frame    = {rd_addr_s1, free_idx};
					rsp_d.status         = ST_OK;
				end else begin
					rsp_d.status = ST_NOFRAME;
				end
			end
			S_LOOK: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = req_q.frame_number[FRAME_W-1:BIT_W];
			end
			S_CHECK: begin
				mem_req.wr_en   = (req_q.mode == MODE_FREE);
				mem_req.wr_addr = req_q.frame_number[FRAME_W-1:BIT_W];
				mem_req.wr_data = rd_data & ~frame_mask;
				rsp_d.status    = ST_OK;
				rsp_d.frame_busy = (req_q.mode == MODE_TEST) &&
					rd_data[req_q.frame_number[BIT_W-1:0]];
			end
			S_DONE: rsp_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			issue_q   <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_req.rd_en && state_q == S_SCAN;
			if (state_q == S_IDLE) begin
				issue_q <= '0;
			end else if (state_q == S_SCAN && mem_req.rd_en) begin
				issue_q <= issue_q + WCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_req.rd_addr;
		if (state_q == S_IDLE) begin
			req_q   <= in_data;
			words_q <= words_d;
		end
		if (state_d == S_DONE && state_q != S_DONE) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	a_write_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |=> state_q == S_DONE)
		else $error("bitmap write not followed by response");

	a_scan_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_req.rd_en) |-> issue_q < words_q)
		else $error("scan read beyond frame limit");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_q.entry_present) |->
			(WCNT_W'(rsp_q.entry_frame[FRAME_W-1:BIT_W]) < words_q))
		else $error("allocated frame outside searched range");

	a_scan_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && mem_req.wr_en) |->
			$countones(mem_req.wr_data) == $countones(rd_data) + 1)
		else $error("allocation must set exactly one bit");

endmodule

[hw/rtl/page_frame_bitmap_allocator.sv]
// Page frame bitmap allocator top level: config register, core and result register.
//
// Requests come in on in_valid/in_ready with in_data (mode, frame_number,
// is_kernel, writable); one result per request leaves on out_valid/out_ready
// with out_data. cfg_we/cfg_data write frame_count, the frame limit searched
// by allocate, taken in whole 32-frame words.
// Free of a nonzero frame and test read the bitmap word in S_LOOK, then
// clear or test the bit in S_CHECK. Allocate with no frame held reads one
// bitmap word per cycle from word 0 up and stops at the first word with a
// free bit or at the last word searched; the single read port of the
// bitmap memory limits that rate. Allocate with a frame held, or with
// frame_count below 32, free of frame 0 and unused modes go straight from
// accept to the result. One request is in work at a time; the next is
// accepted in the cycle after the result moves into the output register.
// Reset clears every usage bit at once through per-word valid flags, so the
// block accepts requests right after reset; frame_count resets to 4096.
// A stalled receiver holds the result in the output register; the core
// finishes the next request and then waits for that register to empty.
module page_frame_bitmap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pfba_pkg::pfba_req_t           in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pfba_pkg::pfba_rsp_t           out_data,
	input  logic                          cfg_we,
	input  logic [pfba_pkg::COUNT_W-1:0]  cfg_data
);
	import pfba_pkg::*;

	logic [COUNT_W-1:0] frame_count_q;
	pfba_mem_req_t      mem_req;
	logic [WORD_W-1:0]  rd_data;
	logic               rsp_valid;
	pfba_rsp_t          rsp;
	logic               rsp_take;
	logic               out_valid_q;
	pfba_rsp_t          out_data_q;

	pfba_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	pfba_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.frame_count (frame_count_q),
		.mem_req     (mem_req),
		.rd_data     (rd_data),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.rsp_take    (rsp_take)
	);

	assign rsp_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_data;
			end
			if (rsp_take) begin
				out_valid_q <= rsp_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take && rsp_valid) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the page frame bitmap allocator.
`timescale 1ns / 1ps

module testbench;
	import pfba_pkg::*;

	localparam int unsigned FRAMES      = WORDS * WORD_W;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	pfba_req_t           in_data;
	logic                out_valid;
	logic                out_ready;
	pfba_rsp_t           out_data;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_data;

	pfba_req_t           req_backlog[$];
	pfba_rsp_t           pending_entries[$];
	bit [FRAMES-1:0]     frame_used;
	int unsigned         search_frames;
	int unsigned         req_issued;
	int unsigned         req_accepted;
	int unsigned         errors;
	int unsigned         cycles;
	bit                  req_taken;
	idle_kind_t          idle_kind;
	bit                  hold_start;
	bit                  hold_taken;
	int unsigned         hold_left;

	page_frame_bitmap_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic pfba_rsp_t predict_entry(pfba_req_t r);
		pfba_rsp_t   e;
		int unsigned span;
		int          found;
		e = '0;
		e.status = ST_NOCHANGE;
		case (r.mode)
			MODE_ALLOC: begin
				if (r.frame_number != 0) begin
					e.entry_frame = r.frame_number;
				end else begin
					span = (search_frames > FRAMES ? FRAMES : search_frames) / WORD_W * WORD_W;
					found = -1;
					for (int f = 0; f < span && found < 0; f++)
						if (!frame_used[f])
							found = f;
					if (found < 0) begin
						e.status = ST_NOFRAME;
					end else begin
						frame_used[found] = 1'b1;
						e.entry_present  = 1'b1;
						e.entry_writable = r.writable;
						e.entry_user     = ~r.is_kernel;
						e.entry_frame    = FRAME_W'(found);
						e.status         = ST_OK;
					end
				end
			end
			MODE_FREE: begin
				if (r.frame_number != 0) begin
					frame_used[r.frame_number] = 1'b0;
					e.status = ST_OK;
				end
			end
			MODE_TEST: begin
				e.frame_busy = frame_used[r.frame_number];
				e.status = ST_OK;
			end
			default: ;
		endcase
		return e;
	endfunction

	function automatic pfba_req_t mk_req(logic [1:0] mode, int unsigned frame, bit kernel, bit wr);
		pfba_req_t r;
		r.mode = mode;
		r.frame_number = FRAME_W'(frame);
		r.is_kernel = kernel;
		r.writable = wr;
		return r;
	endfunction

	// span: how far up the bitmap frees and tests usually aim
	function automatic pfba_req_t gen_request(int unsigned span);
		int unsigned pick;
		bit          kernel;
		bit          wr;
		pick = $urandom_range(0, 99);
		kernel = 1'($urandom_range(0, 1));
		wr = 1'($urandom_range(0, 1));
		if (pick < 48)
			return mk_req(MODE_ALLOC, 0, kernel, wr);
		else if (pick < 53)
			return mk_req(MODE_ALLOC, $urandom_range(1, FRAMES - 1), kernel, wr);
		else if (pick < 70)
			return mk_req(MODE_FREE, $urandom_range(0, span - 1), kernel, wr);
		else if (pick < 74)
			return mk_req(MODE_FREE, $urandom_range(0, FRAMES - 1), kernel, wr);
		else if (pick < 90)
			return mk_req(MODE_TEST, $urandom_range(0, span - 1), kernel, wr);
		else if (pick < 96)
			return mk_req(MODE_TEST, $urandom_range(0, FRAMES - 1), kernel, wr);
		return mk_req(MODE_UNUSED, $urandom_range(0, FRAMES - 1), kernel, wr);
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		errors++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	task automatic check_field(string what, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic queue_req(pfba_req_t r);
		req_backlog.push_back(r);
		req_issued++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		while (req_accepted != req_issued || pending_entries.size() != 0)
			@(negedge clk);
	endtask

	// block is idle here; returns at a rising edge ready for new requests
	task automatic set_frame_count(int unsigned value);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_data <= COUNT_W'(value);
		search_frames = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int unsigned fc, idle_kind_t kind, int unsigned span,
			int unsigned count, bit hold);
		set_frame_count(fc);
		idle_kind = kind;
		repeat (count)
			queue_req(gen_request(span));
		if (hold)
			hold_start = 1'b1;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (req_backlog.size() != 0 &&
					!(idle_kind == IDLE_SEND && $urandom_range(0, 99) < 71) &&
					!(idle_kind == IDLE_BOTH && $urandom_range(0, 99) < 13)) begin
				in_data <= req_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_start && !hold_taken) begin
			out_ready <= 1'b0;
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= !((idle_kind == IDLE_RECV && $urandom_range(0, 99) < 71) ||
				(idle_kind == IDLE_BOTH && $urandom_range(0, 99) < 13));
		end
	end

	// accepted requests, predicted results and the cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** page_frame_bitmap_allocator: FAILED **");
			$finish;
		end
		req_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			pending_entries.push_back(predict_entry(in_data));
			req_accepted++;
		end
	end

	// result monitor
	always @(posedge clk) begin
		pfba_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_entries.size() == 0) begin
				report_mismatch("unexpected result", out_data, 0);
			end else begin
				want = pending_entries.pop_front();
				check_field("entry_present", out_data.entry_present, want.entry_present);
				check_field("entry_writable", out_data.entry_writable, want.entry_writable);
				check_field("entry_user", out_data.entry_user, want.entry_user);
				check_field("entry_frame", out_data.entry_frame, want.entry_frame);
				check_field("status", out_data.status, want.status);
				check_field("frame_busy", out_data.frame_busy, want.frame_busy);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		frame_used = '0;
		search_frames = FRAMES;
		idle_kind = IDLE_NONE;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset frame count, empty bitmap
		queue_req(mk_req(MODE_TEST, 0, 0, 0));
		queue_req(mk_req(MODE_ALLOC, 0, 1, 1));
		queue_req(mk_req(MODE_ALLOC, 0, 0, 0));
		queue_req(mk_req(MODE_ALLOC, 4095, 0, 1));
		queue_req(mk_req(MODE_TEST, 0, 1, 1));
		queue_req(mk_req(MODE_TEST, 4095, 0, 0));
		queue_req(mk_req(MODE_FREE, 0, 1, 1));
		queue_req(mk_req(MODE_FREE, 1, 0, 0));
		queue_req(mk_req(MODE_TEST, 1, 0, 0));
		queue_req(mk_req(MODE_ALLOC, 0, 0, 1));
		queue_req(mk_req(MODE_FREE, 4095, 1, 1));
		queue_req(mk_req(MODE_UNUSED, 4095, 1, 1));
		queue_req(mk_req(MODE_ALLOC, 2048, 1, 0));
		queue_req(mk_req(MODE_FREE, 2048, 0, 0));

		// below one word: nothing searched
		set_frame_count(31);
		queue_req(mk_req(MODE_ALLOC, 0, 1, 1));
		queue_req(mk_req(MODE_TEST, 1, 0, 0));
		set_frame_count(0);
		queue_req(mk_req(MODE_ALLOC, 0, 0, 1));
		// above the bitmap size: clipped
		set_frame_count(8191);
		queue_req(mk_req(MODE_ALLOC, 0, 0, 0));
		queue_req(mk_req(MODE_TEST, 2, 1, 0));

		run_random(64, IDLE_SEND, 64, 200, 1'b0);
		run_random(8191, IDLE_RECV, 256, 250, 1'b0);
		run_random(96, IDLE_BOTH, 96, 200, 1'b0);
		run_random(4096, IDLE_NONE, 512, 200, 1'b1);
		run_random(32, IDLE_NONE, 32, 200, 1'b0);

		wait_drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("** page_frame_bitmap_allocator: PASSED **");
		else
			$display("** page_frame_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
